// File: rtl/core/hkrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hkrd_pkg;

    localparam int INPUT_SLOTS = 6;
    localparam int S_DATA_W    = 128;
    localparam int M_DATA_W    = 88;

    localparam logic [7:0] MIN_BYTES      = 8'd10;
    localparam logic [6:0] CODE_ENTER     = 7'h28;
    localparam logic [6:0] CODE_BACKSPACE = 7'h2A;
    localparam logic [6:0] CODE_TAB       = 7'h2B;
    localparam logic [7:0] SHIFT_MASK     = 8'h22;

    typedef enum logic [1:0] {
        EV_CHAR      = 2'd0,
        EV_ENTER     = 2'd1,
        EV_BACKSPACE = 2'd2,
        EV_TAB       = 2'd3
    } hkrd_event_t;

    // One scanned report handed from the key scan to the event stage
    typedef struct packed {
        logic [7:0]                  modifier;
        logic [INPUT_SLOTS-1:0][7:0] slots;
        logic [62:0]                 when;
        logic [INPUT_SLOTS-1:0]      seen;
    } hkrd_report_t;

    function automatic hkrd_event_t key_kind(input logic [6:0] code);
        hkrd_event_t kind;
        kind = EV_CHAR;
        if (code == CODE_ENTER) begin
            kind = EV_ENTER;
        end else if (code == CODE_BACKSPACE) begin
            kind = EV_BACKSPACE;
        end else if (code == CODE_TAB) begin
            kind = EV_TAB;
        end
        return kind;
    endfunction

    // Boot keyboard usage code to ASCII; zero means unmapped
    function automatic logic [6:0] rom_char(input logic [6:0] code, input logic shift);
        logic [6:0] ch;
        ch = 7'd0;
        case (code) inside
            [7'd4:7'd29]: ch = (shift ? 7'h41 : 7'h61) + (code - 7'd4);
            7'd30:   ch = shift ? 7'h21 : 7'h31;
            7'd31:   ch = shift ? 7'h40 : 7'h32;
            7'd32:   ch = shift ? 7'h23 : 7'h33;
            7'd33:   ch = shift ? 7'h24 : 7'h34;
            7'd34:   ch = shift ? 7'h25 : 7'h35;
            7'd35:   ch = shift ? 7'h5E : 7'h36;
            7'd36:   ch = shift ? 7'h26 : 7'h37;
            7'd37:   ch = shift ? 7'h2A : 7'h38;
            7'd38:   ch = shift ? 7'h28 : 7'h39;
            7'd39:   ch = shift ? 7'h29 : 7'h30;
            7'd40:   ch = 7'h0A;
            7'd42:   ch = 7'h08;
            7'd43:   ch = 7'h09;
            7'd44:   ch = 7'h20;
            7'd45:   ch = shift ? 7'h5F : 7'h2D;
            7'd46:   ch = shift ? 7'h2B : 7'h3D;
            7'd47:   ch = shift ? 7'h7B : 7'h5B;
            7'd48:   ch = shift ? 7'h7D : 7'h5D;
            7'd49:   ch = shift ? 7'h7C : 7'h5C;
            7'd51:   ch = shift ? 7'h3A : 7'h3B;
            7'd52:   ch = shift ? 7'h22 : 7'h27;
            7'd53:   ch = shift ? 7'h7E : 7'h60;
            7'd54:   ch = shift ? 7'h3C : 7'h2C;
            7'd55:   ch = shift ? 7'h3E : 7'h2E;
            7'd56:   ch = shift ? 7'h3F : 7'h2F;
            default: ch = 7'd0;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/hkrd_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module hkrd_scan #(
    parameter int KEY_SLOTS = 6
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [hkrd_pkg::S_DATA_W-1:0] s_tdata,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output hkrd_pkg::hkrd_report_t             res
);
    import hkrd_pkg::*;

    localparam int IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEY_SLOTS - 1);

    // previous report's keys, one entry per slot
    logic [7:0]           key_mem [KEY_SLOTS];
    logic [KEY_SLOTS-1:0] key_ok_reg;
    logic [7:0]           rd_data_reg;
    logic                 rd_ok_reg;

    logic                        busy_reg;
    logic                        rd_go_reg;
    logic [IDX_W-1:0]            rd_idx_reg;
    logic                        cmp_valid_reg;
    logic [IDX_W-1:0]            cmp_idx_reg;
    logic                        res_valid_reg;
    logic [7:0]                  mod_reg;
    logic [INPUT_SLOTS-1:0][7:0] slots_reg;
    logic [62:0]                 time_reg;
    logic [INPUT_SLOTS-1:0]      seen_reg;
    logic [INPUT_SLOTS-1:0]      seen_next;

    logic       accept;
    logic       start;
    logic [7:0] prev_key;
    logic [3:0] cmp_idx_wide;
    logic [7:0] wr_data;

    assign s_tready = !busy_reg && (!res_valid_reg || res_ready);
    assign accept   = s_tvalid && s_tready;
    assign start    = accept && (s_tdata[63:56] >= MIN_BYTES);

    assign prev_key     = rd_ok_reg ? rd_data_reg : 8'd0;
    assign cmp_idx_wide = 4'(cmp_idx_reg);
    assign wr_data      = (cmp_idx_wide < 4'(INPUT_SLOTS)) ? slots_reg[cmp_idx_wide[2:0]] : 8'd0;

    always_comb begin
        for (int i = 0; i < INPUT_SLOTS; i++) begin
            seen_next[i] = seen_reg[i] || (slots_reg[i] == prev_key);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmp_valid_reg) begin
            key_mem[cmp_idx_reg] <= wr_data;
        end
        if (rd_go_reg) begin
            rd_data_reg <= key_mem[rd_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_ok_reg    <= '0;
            rd_ok_reg     <= 1'b0;
            busy_reg      <= 1'b0;
            rd_go_reg     <= 1'b0;
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            if (res_valid_reg && res_ready) begin
                res_valid_reg <= 1'b0;
            end
            if (start) begin
                busy_reg   <= 1'b1;
                rd_go_reg  <= 1'b1;
                rd_idx_reg <= '0;
            end
            cmp_valid_reg <= rd_go_reg;
            if (rd_go_reg) begin
                rd_ok_reg   <= key_ok_reg[rd_idx_reg];
                cmp_idx_reg <= rd_idx_reg;
                if (rd_idx_reg == LAST_IDX) begin
                    rd_go_reg <= 1'b0;
                end else begin
                    rd_idx_reg <= rd_idx_reg + IDX_W'(1);
                end
            end
            // write back this slot's key in the same cycle as its entry is compared
            if (cmp_valid_reg) begin
                key_ok_reg[cmp_idx_reg] <= 1'b1;
                if (cmp_idx_reg == LAST_IDX) begin
                    busy_reg      <= 1'b0;
                    res_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mod_reg   <= s_tdata[7:0];
            slots_reg <= s_tdata[55:8];
            time_reg  <= s_tdata[126:64];
            seen_reg  <= '0;
        end else if (cmp_valid_reg) begin
            seen_reg <= seen_next;
        end
    end

    assign res_valid    = res_valid_reg;
    assign res.modifier = mod_reg;
    assign res.slots    = slots_reg;
    assign res.when     = time_reg;
    assign res.seen     = seen_reg;

endmodule

`default_nettype wire

// File: rtl/core/hkrd_emit.sv
`timescale 1ns / 1ps
`default_nettype none

module hkrd_emit #(
    parameter int KEY_SLOTS = 6
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          res_valid,
    output logic                               res_ready,
    input  wire hkrd_pkg::hkrd_report_t        res,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [hkrd_pkg::M_DATA_W-1:0]      m_tdata,
    output logic [1:0]                         m_tuser,
    output logic                               m_tlast
);
    import hkrd_pkg::*;

    logic        shift;
    hkrd_event_t ld_type [INPUT_SLOTS];
    logic [6:0]  ld_rom  [INPUT_SLOTS];
    logic [6:0]  ld_char [INPUT_SLOTS];
    logic [INPUT_SLOTS-1:0] elig;

    logic [INPUT_SLOTS-1:0] pend_reg;
    hkrd_event_t type_reg [INPUT_SLOTS];
    logic [6:0]  char_reg [INPUT_SLOTS];
    logic [6:0]  code_reg [INPUT_SLOTS];
    logic [7:0]  mod_reg;
    logic [62:0] time_reg;

    logic [INPUT_SLOTS-1:0] pick;
    logic [INPUT_SLOTS-1:0] rest;
    hkrd_event_t sel_type;
    logic [6:0]  sel_char;
    logic [6:0]  sel_code;

    logic        out_valid_reg;
    hkrd_event_t out_type_reg;
    logic [6:0]  out_char_reg;
    logic [6:0]  out_code_reg;
    logic [7:0]  out_mod_reg;
    logic [62:0] out_time_reg;
    logic        out_last_reg;
    logic        advance;

    assign shift     = |(res.modifier & SHIFT_MASK);
    assign res_ready = (pend_reg == '0);
    assign advance   = !out_valid_reg || m_tready;

    always_comb begin
        for (int i = 0; i < INPUT_SLOTS; i++) begin
            ld_type[i] = key_kind(res.slots[i][6:0]);
            ld_rom[i]  = rom_char(res.slots[i][6:0], shift);
            ld_char[i] = (ld_type[i] == EV_CHAR) ? ld_rom[i] : 7'd0;
            elig[i]    = (i < KEY_SLOTS) && !res.seen[i] && (res.slots[i] != 8'd0)
                         && !res.slots[i][7]
                         && ((ld_type[i] != EV_CHAR) || (ld_rom[i] != 7'd0));
        end
    end

    // lowest pending slot goes first
    always_comb begin
        pick     = pend_reg & (~pend_reg + INPUT_SLOTS'(1));
        rest     = pend_reg & ~pick;
        sel_type = EV_CHAR;
        sel_char = 7'd0;
        sel_code = 7'd0;
        for (int i = 0; i < INPUT_SLOTS; i++) begin
            if (pick[i]) begin
                sel_type = type_reg[i];
                sel_char = char_reg[i];
                sel_code = code_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (res_valid && res_ready) begin
                pend_reg <= elig;
            end else if (advance && (pend_reg != '0)) begin
                pend_reg <= rest;
            end
            if (advance) begin
                out_valid_reg <= (pend_reg != '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            for (int i = 0; i < INPUT_SLOTS; i++) begin
                type_reg[i] <= ld_type[i];
                char_reg[i] <= ld_char[i];
                code_reg[i] <= res.slots[i][6:0];
            end
            mod_reg  <= res.modifier;
            time_reg <= res.when;
        end
        if (advance && (pend_reg != '0)) begin
            out_type_reg <= sel_type;
            out_char_reg <= sel_char;
            out_code_reg <= sel_code;
            out_mod_reg  <= (sel_type == EV_CHAR) ? mod_reg : 8'd0;
            out_time_reg <= time_reg;
            out_last_reg <= (rest == '0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_time_reg, out_mod_reg, out_code_reg, out_char_reg};
    assign m_tuser  = out_type_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// File: rtl/core/hid_keyboard_report_decoder_top.sv
// Channel  | Dir | Beat content (lowest bit first)
// s_       | in  | tdata: modifier_bits, key_slot_0..5, byte_count, capture_time
// m_       | out | tdata: character, key_code, modifier_out, event_time;
//          |     | tuser: event_type; tlast: last_of_report
//
// A report scans the previous keys from memory, one entry per cycle; a new report is
// taken only once that scan is finished and its result can be handed on, and a
// report shorter than 10 bytes is accepted and dropped without a scan.
// Events leave one per cycle behind an output register; m_tready low stalls the
// event stage, and the scan then holds its finished report. Reset clears the key
// valid bits, so every stored key reads as zero until the next report writes it.
`timescale 1ns / 1ps
`default_nettype none

module hid_keyboard_report_decoder_top #(
    parameter int KEY_SLOTS = 6
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // modifier_bits, key_slot_0..key_slot_5, byte_count, capture_time, pad
    input  wire logic [hkrd_pkg::S_DATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // character, key_code, modifier_out, event_time, pad
    output logic [hkrd_pkg::M_DATA_W-1:0]      m_tdata,
    // event_type
    output logic [1:0]                         m_tuser,
    output logic                               m_tlast
);
    import hkrd_pkg::*;

    logic         res_valid;
    logic         res_ready;
    hkrd_report_t res;

    hkrd_scan #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    hkrd_emit #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

`ifndef SYNTHESIS
    // hold off new reports while a scanned one waits on the event stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res_ready) |-> !s_tready)
        else $error("report accepted while scan result is blocked");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != EV_CHAR)) |-> ((m_tdata[6:0] == 7'd0) && (m_tdata[21:14] == 8'd0)))
        else $error("special event carries character or modifier");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == EV_CHAR)) |-> (m_tdata[6:0] != 7'd0))
        else $error("character event with unmapped code");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[13:7] != 7'd0))
        else $error("event with empty key code");
`endif

endmodule

`default_nettype wire

// File: tb/keyboard_event_checker.sv
`timescale 1ns / 1ps

module keyboard_event_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    // modifier_bits, key_slot_0..key_slot_5, byte_count, capture_time, pad
    input  wire logic [hkrd_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    // character, key_code, modifier_out, event_time, pad
    input  wire logic [hkrd_pkg::M_DATA_W-1:0] m_tdata,
    // event_type
    input  wire logic [1:0]                    m_tuser,
    input  wire logic                          m_tlast,
    output int                                 error_count,
    output int                                 pending_events
);
    import hkrd_pkg::*;

    localparam int         SLOTS            = 6;
    localparam logic [7:0] KEY_FIRST_MAPPED = 8'd4;
    localparam logic [7:0] KEY_LAST_MAPPED  = 8'd56;
    localparam logic [7:0] KEY_ESCAPE       = 8'h29;
    localparam logic [7:0] KEY_NONUS_HASH   = 8'h32;
    localparam logic [7:0] CODE_LIMIT       = 8'd128;

    typedef struct {
        hkrd_event_t kind;
        logic [6:0]  ch;
        logic [6:0]  code;
        logic [7:0]  mods;
        logic [62:0] stamp;
        logic        last;
    } key_event_t;

    // Characters for codes 4..56; '?' fills positions that never map to a char
    string plain_chars = {"abcdefghijklmnopqrstuvwxyz", "1234567890", "????",
                          " -=[]\\?;'`,./"};
    string shift_chars = {"ABCDEFGHIJKLMNOPQRSTUVWXYZ", "!@#$%^&*()", "????",
                          " _+{}|?:\"~<>?"};

    logic [7:0]  held_keys [SLOTS];
    key_event_t  expected_events [$];

    initial begin
        error_count    = 0;
        pending_events = 0;
    end

    function automatic logic [6:0] ascii_of(input logic [7:0] code, input logic shifted);
        byte c;
        if (code < KEY_FIRST_MAPPED || code > KEY_LAST_MAPPED ||
            code == KEY_ESCAPE || code == KEY_NONUS_HASH) begin
            return 7'd0;
        end
        c = shifted ? shift_chars[code - KEY_FIRST_MAPPED]
                    : plain_chars[code - KEY_FIRST_MAPPED];
        return c[6:0];
    endfunction

    task automatic decode_report(input logic [S_DATA_W-1:0] beat);
        logic [7:0]  mods;
        logic [7:0]  count;
        logic [62:0] stamp;
        logic [7:0]  code;
        logic        shifted;
        logic        seen;
        int          first_new;
        key_event_t  ev;
        mods      = beat[7:0];
        count     = beat[63:56];
        stamp     = beat[126:64];
        shifted   = (mods & SHIFT_MASK) != 0;
        first_new = expected_events.size();
        // drop short reports without touching the held keys
        if (count < MIN_BYTES) return;
        for (int i = 0; i < SLOTS; i++) begin
            code = beat[8 + 8*i +: 8];
            seen = 1'b0;
            for (int j = 0; j < SLOTS; j++) begin
                if (held_keys[j] == code) seen = 1'b1;
            end
            if (code == 8'd0 || code >= CODE_LIMIT || seen) continue;
            ev.ch    = 7'd0;
            ev.mods  = 8'd0;
            ev.code  = code[6:0];
            ev.stamp = stamp;
            ev.last  = 1'b0;
            if (code[6:0] == CODE_ENTER) begin
                ev.kind = EV_ENTER;
            end else if (code[6:0] == CODE_BACKSPACE) begin
                ev.kind = EV_BACKSPACE;
            end else if (code[6:0] == CODE_TAB) begin
                ev.kind = EV_TAB;
            end else begin
                ev.kind = EV_CHAR;
                ev.ch   = ascii_of(code, shifted);
                ev.mods = mods;
                if (ev.ch == 7'd0) continue;
            end
            expected_events.push_back(ev);
        end
        if (expected_events.size() > first_new) begin
            expected_events[expected_events.size() - 1].last = 1'b1;
        end
        for (int i = 0; i < SLOTS; i++) held_keys[i] = beat[8 + 8*i +: 8];
    endtask

    task automatic compare_event(input key_event_t exp_ev);
        if (m_tuser != exp_ev.kind) begin
            $error("event_type expected %0d got %0d", exp_ev.kind, m_tuser);
            error_count++;
        end
        if (m_tdata[6:0] != exp_ev.ch) begin
            $error("character expected 0x%02h got 0x%02h", exp_ev.ch, m_tdata[6:0]);
            error_count++;
        end
        if (m_tdata[13:7] != exp_ev.code) begin
            $error("key_code expected 0x%02h got 0x%02h", exp_ev.code, m_tdata[13:7]);
            error_count++;
        end
        if (m_tdata[21:14] != exp_ev.mods) begin
            $error("modifier_out expected 0x%02h got 0x%02h", exp_ev.mods, m_tdata[21:14]);
            error_count++;
        end
        if (m_tdata[84:22] != exp_ev.stamp) begin
            $error("event_time expected %0d got %0d", exp_ev.stamp, m_tdata[84:22]);
            error_count++;
        end
        if (m_tlast != exp_ev.last) begin
            $error("last_of_report expected %0d got %0d", exp_ev.last, m_tlast);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) held_keys[i] = 8'd0;
            expected_events.delete();
        end else begin
            if (s_tvalid && s_tready) decode_report(s_tdata);
            if (m_tvalid && m_tready) begin
                if (expected_events.size() == 0) begin
                    $error("unexpected event beat: key_code 0x%02h", m_tdata[13:7]);
                    error_count++;
                end else begin
                    compare_event(expected_events.pop_front());
                end
            end
        end
        pending_events = expected_events.size();
    end

endmodule

// File: tb/tb_hid_keyboard_report_decoder_top.sv
`timescale 1ns / 1ps

module tb_hid_keyboard_report_decoder_top;
    import hkrd_pkg::*;

    localparam int         RANDOM_REPORTS = 320;
    localparam logic [7:0] KEY_A          = 8'h04;
    localparam logic [7:0] KEY_ESCAPE     = 8'h29;
    localparam logic [7:0] KEY_NONUS_HASH = 8'h32;
    localparam logic [7:0] KEY_CAPS_LOCK  = 8'h39;
    localparam logic [7:0] KEY_LAST_MAPPED = 8'd56;
    localparam logic [7:0] MOD_LSHIFT     = 8'h02;
    localparam logic [7:0] MOD_RSHIFT     = 8'h20;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [1:0]          m_tuser;
    logic                m_tlast;

    int          error_count;
    int          pending_events;
    int          gap_pct   = 0;
    int          stall_pct = 0;
    logic [7:0]  last_slots [6];
    logic [62:0] clock_us  = 63'd1000;

    always #4 aclk = ~aclk;

    hid_keyboard_report_decoder_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    keyboard_event_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .error_count    (error_count),
        .pending_events (pending_events)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Hold the beat until the block takes it
    task automatic send_report(input logic [7:0] mods, input logic [7:0] k0,
                               input logic [7:0] k1, input logic [7:0] k2,
                               input logic [7:0] k3, input logic [7:0] k4,
                               input logic [7:0] k5, input logic [7:0] count,
                               input logic [62:0] stamp);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, stamp, count, k5, k4, k3, k2, k1, k0, mods};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        last_slots = '{k0, k1, k2, k3, k4, k5};
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_events != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_slot(input int i);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35) return 8'd0;
        if (roll < 60) return last_slots[i];
        if (roll < 95) return 8'($urandom_range(KEY_A, KEY_LAST_MAPPED));
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_modifier();
        case ($urandom_range(0, 4))
            0, 1:    return 8'd0;
            2:       return MOD_LSHIFT;
            3:       return MOD_RSHIFT;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic random_report();
        logic [7:0]  k [6];
        logic [7:0]  mods;
        logic [7:0]  count;
        logic [62:0] stamp;
        if ($urandom_range(0, 9) == 0) begin
            // noise: any byte in any field
            for (int i = 0; i < 6; i++) k[i] = 8'($urandom);
            mods  = 8'($urandom);
            count = 8'($urandom);
            stamp = {31'($urandom), 32'($urandom)};
        end else begin
            for (int i = 0; i < 6; i++) k[i] = pick_slot(i);
            mods  = pick_modifier();
            count = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 9))
                                                : 8'($urandom_range(10, 255));
            clock_us = clock_us + 63'($urandom_range(900, 1100));
            stamp = clock_us;
        end
        send_report(mods, k[0], k[1], k[2], k[3], k[4], k[5], count, stamp);
    endtask

    initial begin
        int sent;
        for (int i = 0; i < 6; i++) last_slots[i] = 8'd0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // short reports are dropped and leave no trace, so the full report after them sees no held keys
        send_report(8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'd9, 63'd1);
        send_report(8'hFF, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'd0, 63'd2);
        send_report(8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'd10, '1);
        // held keys give nothing
        send_report(8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'd255, 63'd3);
        send_report(MOD_LSHIFT, 8'd30, 8'd31, 8'd32, 8'd33, 8'd34, 8'd35, 8'd10, 63'd4);
        send_report(MOD_RSHIFT, 8'd36, 8'd37, 8'd38, 8'd39, 8'd44, 8'd45, 8'd12, 63'd5);
        send_report(8'hFF, CODE_ENTER, KEY_ESCAPE, CODE_BACKSPACE, CODE_TAB,
                    KEY_NONUS_HASH, KEY_CAPS_LOCK, 8'd10, 63'd0);
        send_report(8'h00, 8'h80, 8'hFF, 8'h7F, 8'h46, 8'h00, 8'h00, 8'd10, 63'd6);
        send_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd10, 63'd7);
        send_report(8'hDD, 8'h04, 8'h04, 8'h05, 8'h05, 8'h00, 8'h00, 8'd10, 63'd8);
        send_report(8'h00, 8'd46, 8'd47, 8'd48, 8'd49, 8'd51, 8'd52, 8'd10, 63'd9);
        send_report(MOD_LSHIFT, 8'd53, 8'd54, 8'd55, 8'd56, 8'd46, 8'd47, 8'd10, 63'd10);
        send_report(MOD_RSHIFT, 8'd48, 8'd49, 8'd51, 8'd52, 8'h00, 8'h00, 8'd10, 63'd11);
        send_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd10, 63'd12);
        // a short report in between must not update the held keys
        send_report(8'h00, 8'h1D, 8'h1C, 8'h00, 8'h00, 8'h00, 8'h00, 8'd10, 63'd13);
        send_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd3, 63'd14);
        send_report(8'h00, 8'h1D, 8'h1C, 8'h2C, 8'h00, 8'h00, 8'h00, 8'd10, 63'd15);
        wait_drained();

        sent = 0;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 50; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 50; end
                default: begin gap_pct = 38; stall_pct = 38; end
            endcase
            while (sent < (phase + 1) * RANDOM_REPORTS / 4) begin
                random_report();
                sent++;
            end
            wait_drained();
        end

        if (error_count == 0 && pending_events == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
